@@ hw/rtl/srl_pkg.sv @@
// Shared types and constants for the source request limiter.
package srl_pkg;

    localparam int ADDR_W = 64;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic lookup;
        logic update;
    } t_cmd;

endpackage

@@ hw/rtl/srl_ctrl.sv @@
// Controller state machine for the source request limiter.
module srl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output srl_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state == ST_UPDATE);
    assign o_cmd.lookup = (r_state == ST_IDLE) && i_start;
    assign o_cmd.update = (r_state == ST_UPDATE);

endmodule

@@ hw/rtl/srl_datapath.sv @@
// Datapath: source address table, per-entry count memory and result registers.
module srl_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srl_pkg::t_cmd               i_cmd,
    input  logic [srl_pkg::ADDR_W-1:0]  i_addr_hi,
    input  logic [srl_pkg::ADDR_W-1:0]  i_addr_lo,
    input  logic                        i_cfg_we,
    input  logic [srl_pkg::COUNT_W-1:0] i_cfg_wdata,
    output logic                        o_done,
    output logic [srl_pkg::COUNT_W-1:0] o_request_count,
    output logic                        o_banned,
    output logic                        o_new_entry
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    logic [srl_pkg::ADDR_W-1:0]  r_key_hi [ENTRIES];
    logic [srl_pkg::ADDR_W-1:0]  r_key_lo [ENTRIES];
    logic [ENTRIES-1:0]          r_valid;
    logic [srl_pkg::COUNT_W-1:0] r_count_mem [ENTRIES];
    logic [IW-1:0]               r_ptr;
    logic [srl_pkg::COUNT_W-1:0] r_req_limit;

    logic [srl_pkg::ADDR_W-1:0]  r_addr_hi;
    logic [srl_pkg::ADDR_W-1:0]  r_addr_lo;
    logic                        r_hit;
    logic [IW-1:0]               r_hit_idx;
    logic [srl_pkg::COUNT_W-1:0] r_count_rd;

    logic                        r_done;
    logic [srl_pkg::COUNT_W-1:0] r_request_count;
    logic                        r_banned;
    logic                        r_new_entry;

    logic [ENTRIES-1:0]          match;
    logic [IW-1:0]               hit_idx;
    logic [srl_pkg::COUNT_W-1:0] n_count;
    logic [IW-1:0]               wr_idx;
    logic [IW-1:0]               n_ptr;

    // Compare the incoming address against every valid entry at once.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key_hi[i] == i_addr_hi) && (r_key_lo[i] == i_addr_lo);
        end
    end

    // An address is only inserted on a miss, so at most one entry matches and
    // the index can be formed by OR-ing the indices of the matching entries.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    always_comb begin
        if (r_hit) begin
            n_count = (r_count_rd == srl_pkg::COUNT_MAX) ? r_count_rd
                                                         : r_count_rd + srl_pkg::COUNT_ONE;
        end else begin
            n_count = srl_pkg::COUNT_ONE;
        end
    end

    assign wr_idx = r_hit ? r_hit_idx : r_ptr;
    assign n_ptr  = (r_ptr == LAST_IDX) ? '0 : r_ptr + IW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_addr_hi  <= i_addr_hi;
            r_addr_lo  <= i_addr_lo;
            r_hit      <= |match;
            r_hit_idx  <= hit_idx;
            r_count_rd <= r_count_mem[hit_idx];
        end
        if (i_cmd.update) begin
            r_count_mem[wr_idx] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !r_hit) begin
            r_key_hi[r_ptr] <= r_addr_hi;
            r_key_lo[r_ptr] <= r_addr_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ptr       <= '0;
            r_req_limit <= srl_pkg::LIMIT_RESET;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
            if (i_cfg_we) begin
                r_req_limit <= i_cfg_wdata;
            end
            if (i_cmd.update && !r_hit) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= n_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_request_count <= n_count;
            r_banned        <= (n_count > r_req_limit);
            r_new_entry     <= !r_hit;
        end
    end

    assign o_done          = r_done;
    assign o_request_count = r_request_count;
    assign o_banned        = r_banned;
    assign o_new_entry     = r_new_entry;

endmodule

@@ hw/rtl/source_request_limiter.sv @@
// A transaction is looked up while the controller is idle and updated in its update state;
// the result is registered and strobed on o_done. No new transaction is accepted while o_busy
// is high for the count memory read-modify-write; the receiver cannot stall the result strobe.
// Reset (synchronous, active low) clears all entry valid bits, the insert pointer and the
// controller, and sets the request limit to 3; keys and counts are not cleared and no sweep runs.
module source_request_limiter #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [srl_pkg::ADDR_W-1:0]  i_addr_hi,
    input  logic [srl_pkg::ADDR_W-1:0]  i_addr_lo,
    input  logic                        i_cfg_we,
    input  logic [srl_pkg::COUNT_W-1:0] i_cfg_wdata,
    output logic                        o_done,
    output logic [srl_pkg::COUNT_W-1:0] o_request_count,
    output logic                        o_banned,
    output logic                        o_new_entry
);

    // The controller walks each transaction through two steps. In the first
    // step, while idle, the address on the ports is compared against every
    // valid table entry, and the count of the matching entry is read from the
    // count memory into a register. In the second step the count is
    // incremented (saturating) or, on a miss, the address is written into the
    // slot under the round-robin insert pointer with a count of one. The
    // result is registered and strobed on o_done for one cycle, during which
    // the next transaction may already be accepted.

    srl_pkg::t_cmd cmd;

    srl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    // The datapath holds the key table, valid bits, count memory, insert
    // pointer and the request limit register. Configuration writes are taken
    // at any edge; the user must issue them only while the block is idle (not enforced).
    srl_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr_hi       (i_addr_hi),
        .i_addr_lo       (i_addr_lo),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_request_count (o_request_count),
        .o_banned        (o_banned),
        .o_new_entry     (o_new_entry)
    );

endmodule

@@ hw/rtl/srl_checker.sv @@
// Port-level assertions for the source request limiter, with the bind that attaches them.
module srl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_done,
    input logic [srl_pkg::COUNT_W-1:0] o_request_count,
    input logic                        o_new_entry
);

    // Every accepted transaction is followed by the busy update step and then by its result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy ##1 o_done))
        else $error("result strobe did not follow an accepted transaction");

    // The update step lasts a single cycle.
    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> !o_busy)
        else $error("busy held for more than one cycle");

    // Result strobes never come back to back.
    a_done_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe on consecutive cycles");

    // A newly inserted source always reports a count of one.
    a_new_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_new_entry) |-> (o_request_count == srl_pkg::COUNT_ONE))
        else $error("new entry reported a count other than one");

    // A known source never reports a count below two.
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_new_entry) |-> (o_request_count > srl_pkg::COUNT_ONE))
        else $error("existing entry reported a count below two");

endmodule

bind source_request_limiter srl_checker u_srl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_done          (o_done),
    .o_request_count (o_request_count),
    .o_new_entry     (o_new_entry)
);

@@ verif/source_request_limiter_checker.sv @@
`timescale 1ns / 100ps
// Watches the limiter's request and result channels, predicts each verdict and compares it.
module source_request_limiter_checker #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [srl_pkg::ADDR_W-1:0]  i_addr_hi,
    input  logic [srl_pkg::ADDR_W-1:0]  i_addr_lo,
    input  logic                        i_cfg_we,
    input  logic [srl_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                        i_done,
    input  logic [srl_pkg::COUNT_W-1:0] i_request_count,
    input  logic                        i_banned,
    input  logic                        i_new_entry,
    output int                          o_pending,
    output int                          o_errors
);

    typedef struct packed {
        logic [srl_pkg::COUNT_W-1:0] count;
        logic                        banned;
        logic                        new_entry;
    } t_verdict;

    // Private copy of the source table and the limit register.
    logic [srl_pkg::ADDR_W-1:0]  tag_hi [ENTRIES];
    logic [srl_pkg::ADDR_W-1:0]  tag_lo [ENTRIES];
    bit                          known [ENTRIES];
    logic [srl_pkg::COUNT_W-1:0] seen_count [ENTRIES];
    int                          fill_ptr;
    logic [srl_pkg::COUNT_W-1:0] request_limit;

    t_verdict pending_verdicts [$];
    int       mismatches = 0;

    assign o_errors = mismatches;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Looks the source up, updates its count or inserts it, and returns the verdict.
    function automatic t_verdict count_request(input logic [srl_pkg::ADDR_W-1:0] hi,
                                               input logic [srl_pkg::ADDR_W-1:0] lo);
        t_verdict v;
        int       hit;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && known[i] && tag_hi[i] == hi && tag_lo[i] == lo) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            if (seen_count[hit] != srl_pkg::COUNT_MAX) begin
                seen_count[hit] = seen_count[hit] + srl_pkg::COUNT_ONE;
            end
            v.count     = seen_count[hit];
            v.new_entry = 1'b0;
        end else begin
            tag_hi[fill_ptr]     = hi;
            tag_lo[fill_ptr]     = lo;
            known[fill_ptr]      = 1'b1;
            seen_count[fill_ptr] = srl_pkg::COUNT_ONE;
            v.count              = srl_pkg::COUNT_ONE;
            v.new_entry          = 1'b1;
            fill_ptr             = (fill_ptr + 1) % ENTRIES;
        end
        v.banned = (v.count > request_limit);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                known[i]      = 1'b0;
                seen_count[i] = '0;
            end
            fill_ptr      = 0;
            request_limit = srl_pkg::LIMIT_RESET;
            pending_verdicts.delete();
        end else begin
            if ($isunknown(i_done)) begin
                report_mismatch("result strobe is unknown");
            end else if (i_done) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_request_count !== want.count) begin
                        report_mismatch($sformatf("request_count %0d, expected %0d",
                                                  i_request_count, want.count));
                    end
                    if (i_banned !== want.banned) begin
                        report_mismatch($sformatf("banned %b, expected %b",
                                                  i_banned, want.banned));
                    end
                    if (i_new_entry !== want.new_entry) begin
                        report_mismatch($sformatf("new_entry %b, expected %b",
                                                  i_new_entry, want.new_entry));
                    end
                end
            end
            if (i_cfg_we) begin
                request_limit = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                pending_verdicts.push_back(count_request(i_addr_hi, i_addr_lo));
            end
        end
        o_pending <= pending_verdicts.size();
    end

endmodule

@@ verif/source_request_limiter_tb.sv @@
`timescale 1ns / 100ps
// Top of the source request limiter testbench: clock, reset, stimulus and the final verdict.
module source_request_limiter_tb;

    localparam int ENTRIES   = 16;
    localparam int POOL_SIZE = 24;
    localparam int HOT_SIZE  = 6;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_start = 1'b0;
    logic                        o_busy;
    logic [srl_pkg::ADDR_W-1:0]  i_addr_hi = '0;
    logic [srl_pkg::ADDR_W-1:0]  i_addr_lo = '0;
    logic                        i_cfg_we = 1'b0;
    logic [srl_pkg::COUNT_W-1:0] i_cfg_wdata = '0;
    logic                        o_done;
    logic [srl_pkg::COUNT_W-1:0] o_request_count;
    logic                        o_banned;
    logic                        o_new_entry;

    int pending;
    int errors;

    // Addresses that the random part keeps coming back to. The pool is larger than
    // the table, so sources are evicted and return as new entries, while the first
    // few are drawn often enough that their counts climb past the limit.
    logic [srl_pkg::ADDR_W-1:0] pool_hi [POOL_SIZE];
    logic [srl_pkg::ADDR_W-1:0] pool_lo [POOL_SIZE];

    source_request_limiter #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_addr_hi      (i_addr_hi),
        .i_addr_lo      (i_addr_lo),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_request_count(o_request_count),
        .o_banned       (o_banned),
        .o_new_entry    (o_new_entry)
    );

    source_request_limiter_checker #(
        .ENTRIES(ENTRIES)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_addr_hi      (i_addr_hi),
        .i_addr_lo      (i_addr_lo),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_done         (o_done),
        .i_request_count(o_request_count),
        .i_banned       (o_banned),
        .i_new_entry    (o_new_entry),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run may not take longer than this; the slowest legal run, with the longest
    // sender gap before every transaction, needs about a tenth of it.
    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [srl_pkg::ADDR_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Presents one transaction and holds it until the block takes it. With a chance
    // of idle_pct in a hundred the sender first drops start for a random gap, so that
    // requests land on every phase of the lookup and update steps.
    // Inputs and o_busy are read right after the edge, so both are the values the
    // block saw at that edge.
    task automatic send_request(input logic [srl_pkg::ADDR_W-1:0] hi,
                                input logic [srl_pkg::ADDR_W-1:0] lo,
                                input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_addr_hi <= hi;
        i_addr_lo <= lo;
        do begin
            @(posedge i_clk);
        end while (o_busy);
    endtask

    // The sender stops until every outstanding transaction has produced its result,
    // then lets the block settle back to idle.
    task automatic drain();
        i_start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called with the block idle, right after a drain.
    task automatic write_limit(input logic [srl_pkg::COUNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Most traffic repeats known sources; the rest is fresh random addresses.
    task automatic run_traffic(input int n, input int idle_pct);
        int pick;
        int roll;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 50) begin
                pick = $urandom_range(HOT_SIZE - 1);
                send_request(pool_hi[pick], pool_lo[pick], idle_pct);
            end else if (roll < 80) begin
                pick = $urandom_range(POOL_SIZE - 1);
                send_request(pool_hi[pick], pool_lo[pick], idle_pct);
            end else begin
                send_request(random_word(), random_word(), idle_pct);
            end
        end
    endtask

    initial begin
        logic [srl_pkg::ADDR_W-1:0] fill_hi;

        // Entries two and three of each triple share one half with entry one and differ
        // from it in a single bit of the other half, so a match must need both halves.
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i % 3 == 1) begin
                pool_hi[i] = pool_hi[i-1];
                pool_lo[i] = pool_lo[i-1] ^ (64'd1 << $urandom_range(63));
            end else if (i % 3 == 2) begin
                pool_hi[i] = pool_hi[i-2] ^ (64'd1 << $urandom_range(63));
                pool_lo[i] = pool_lo[i-2];
            end else begin
                pool_hi[i] = random_word();
                pool_lo[i] = random_word();
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset limit of three. The all-zero source is counted
        // up until it is banned; sources equal to it in one half only must miss.
        send_request('0, '0, 8);
        send_request('0, '0, 8);
        send_request('1, '1, 8);
        send_request('0, '1, 8);
        send_request('1, '0, 8);
        send_request('0, '0, 8);
        send_request('0, '0, 8);
        // Thirteen more new sources fill the table and wrap the insert pointer, so the
        // seventeenth insertion evicts the oldest entry, the all-zero source.
        for (int k = 0; k < 13; k++) begin
            fill_hi = {32'h5555_5555, 32'(k)};
            send_request(fill_hi, ~fill_hi, 8);
        end
        // The evicted source comes back as new and takes the slot of the all-ones one,
        // which is then new again as well.
        send_request('0, '0, 8);
        send_request('1, '1, 8);
        send_request('0, '1, 8);
        send_request('0, '1, 8);
        send_request('0, '1, 8);
        drain();

        // A limit of zero bans every source, new ones included.
        write_limit('0);
        run_traffic(550, 8);
        drain();

        // The highest limit never bans.
        write_limit(srl_pkg::COUNT_MAX);
        run_traffic(550, 47);
        drain();

        write_limit(srl_pkg::COUNT_W'($urandom_range(1, 12)));
        run_traffic(550, 0);
        drain();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ source_request_limiter.f @@
hw/rtl/srl_pkg.sv
hw/rtl/srl_ctrl.sv
hw/rtl/srl_datapath.sv
hw/rtl/source_request_limiter.sv
hw/rtl/srl_checker.sv
verif/source_request_limiter_checker.sv
verif/source_request_limiter_tb.sv
